[rtl/abrf_pkg.sv]
package abrf_pkg;

    localparam int COORD_W = 9;
    localparam int CFG_W   = 9;

    localparam logic [1:0] KIND_FILL  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [31:0]        color;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  done_kind;
        logic [31:0] pixel_data;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_SKIP  = 2'd0,
        OP_SET   = 2'd1,
        OP_BLEND = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // one classified request, rectangle already clamped
    typedef struct packed {
        op_t                op;
        logic [1:0]         kind;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] rows;
        logic [COORD_W-1:0] w;
        logic [31:0]        color;
    } job_t;

endpackage

[rtl/abrf_front.sv]
module abrf_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int AW         = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  abrf_pkg::cmd_t                cmd,
    input  logic [abrf_pkg::CFG_W-1:0]    frame_width,
    input  logic [abrf_pkg::CFG_W-1:0]    frame_height,
    output logic                          push,
    output abrf_pkg::job_t                push_job,
    output logic [AW-1:0]                 push_base,
    input  logic                          q_full
);
    import abrf_pkg::*;

    localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
    localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);

    logic                   f_valid_reg, f_valid_next;
    job_t                   f_job_reg, f_job_next;
    logic [COORD_W-1:0]     f_y0_reg, f_y0_next;
    logic                   accept;
    logic [COORD_W-1:0]     w_eff, h_eff;
    logic [COORD_W-1:0]     cx0, cx1, cy0, cy1;
    logic                   hit;
    logic [7:0]             alpha;
    logic [2*COORD_W-1:0]   base_prod;

    function automatic logic [COORD_W-1:0] clamp(input logic signed [15:0] v,
                                                 input logic [COORD_W-1:0] hi);
        logic signed [15:0] hs;
        hs = $signed({7'b0, hi});
        if (v < 0)
            clamp = '0;
        else if (v > hs)
            clamp = hi;
        else
            clamp = v[COORD_W-1:0];
    endfunction

    assign busy   = f_valid_reg | q_full;
    assign accept = start & ~busy;
    assign push   = f_valid_reg & ~q_full;

    assign w_eff = ({4'b0, frame_width} > MAXW) ? MAXW[COORD_W-1:0] : frame_width;
    assign h_eff = ({4'b0, frame_height} > MAXH) ? MAXH[COORD_W-1:0] : frame_height;

    assign cx0   = clamp(cmd.start_x, w_eff);
    assign cx1   = clamp(cmd.end_x, w_eff);
    assign cy0   = clamp(cmd.start_y, h_eff);
    assign cy1   = clamp(cmd.end_y, h_eff);
    assign alpha = cmd.color[31:24];
    assign hit   = (cmd.start_x >= 0) && (cmd.start_y >= 0)
                && (cmd.start_x < $signed({7'b0, w_eff}))
                && (cmd.start_y < $signed({7'b0, h_eff}));

    always_comb
    begin
        f_job_next       = f_job_reg;
        f_y0_next        = f_y0_reg;
        f_valid_next     = f_valid_reg;
        if (accept)
        begin
            f_valid_next     = 1'b1;
            f_job_next.kind  = cmd.kind;
            f_job_next.w     = w_eff;
            f_job_next.color = cmd.color;
            f_job_next.op    = OP_SKIP;
            f_job_next.x0    = cmd.start_x[COORD_W-1:0];
            f_job_next.x1    = cmd.start_x[COORD_W-1:0] + 1'b1;
            f_job_next.rows  = COORD_W'(1);
            f_y0_next        = cmd.start_y[COORD_W-1:0];
            unique case (cmd.kind)
                KIND_FILL:
                begin
                    f_job_next.x0   = cx0;
                    f_job_next.x1   = cx1;
                    f_job_next.rows = cy1 - cy0;
                    f_y0_next       = cy0;
                    if (alpha == 8'd0 || cx0 >= cx1 || cy0 >= cy1)
                        f_job_next.op = OP_SKIP;
                    else if (alpha == 8'hFF)
                        f_job_next.op = OP_SET;
                    else
                        f_job_next.op = OP_BLEND;
                end
                KIND_WRITE: f_job_next.op = hit ? OP_SET : OP_SKIP;
                KIND_READ:  f_job_next.op = hit ? OP_READ : OP_SKIP;
                default:    f_job_next.op = OP_SKIP;
            endcase
        end
        else if (push)
        begin
            f_valid_next = 1'b0;
        end
    end

    assign base_prod = {{COORD_W{1'b0}}, f_y0_reg} * {{COORD_W{1'b0}}, f_job_reg.w};
    assign push_job  = f_job_reg;
    assign push_base = AW'(base_prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        f_job_reg <= f_job_next;
        f_y0_reg  <= f_y0_next;
    end

endmodule

[rtl/abrf_queue.sv]
module abrf_queue #(
    parameter int AW = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  abrf_pkg::job_t push_job,
    input  logic [AW-1:0]  push_base,
    output logic           full,
    output logic           not_empty,
    input  logic           pop,
    output abrf_pkg::job_t pop_job,
    output logic [AW-1:0]  pop_base
);
    import abrf_pkg::*;

    job_t          jobs_reg [2];
    logic [AW-1:0] bases_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_job   = jobs_reg[rd_ptr_reg];
    assign pop_base  = bases_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            jobs_reg[wr_ptr_reg]  <= push_job;
            bases_reg[wr_ptr_reg] <= push_base;
        end
    end

endmodule

[rtl/abrf_back.sv]
module abrf_back #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  abrf_pkg::job_t q_job,
    input  logic [AW-1:0]  q_base,
    output logic           q_pop,
    output logic           done,
    output abrf_pkg::rsp_t result
);
    import abrf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [1:0]         kind_reg, kind_next;
    logic [COORD_W-1:0] x0_reg, x0_next;
    logic [COORD_W-1:0] x1_reg, x1_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] rows_reg, rows_next;
    logic [COORD_W-1:0] w_reg, w_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [31:0]        color_reg, color_next;

    logic               p1_valid_reg, p1_valid_next;
    logic [AW-1:0]      p1_addr_reg;
    logic               p2_valid_reg, p2_valid_next;
    logic [AW-1:0]      p2_addr_reg;
    logic [15:0]        sum_r_reg, sum_g_reg, sum_b_reg;

    logic [31:0]        mem [DEPTH];
    logic [31:0]        rdata_reg;

    logic [AW-1:0]      addr;
    logic               rd_en;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [31:0]        wdata;
    logic               x_last;
    logic               pipe_empty;
    logic [7:0]         alpha;

    function automatic logic [15:0] mix(input logic [7:0] a, input logic [7:0] nw,
                                        input logic [7:0] old);
        logic [15:0] pa, pb;
        pa  = {8'b0, a} * {8'b0, nw};
        pb  = {8'b0, ~a} * {8'b0, old};
        mix = pa + pb;
    endfunction

    // floor(v / 255) for v up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t      = {1'b0, v} + {9'b0, v[15:8]} + 17'd1;
        div255 = t[15:8];
    endfunction

    assign alpha      = color_reg[31:24];
    assign addr       = base_reg + AW'(x_reg);
    assign rd_en      = (state_reg == S_RUN);
    assign x_last     = ((x_reg + 1'b1) == x1_reg);
    assign pipe_empty = ~p1_valid_reg & ~p2_valid_reg;
    assign q_pop      = (state_reg == S_IDLE) && q_valid;

    assign done              = (state_reg == S_DRAIN) && pipe_empty;
    assign result.done_kind  = kind_reg;
    assign result.pixel_data = (op_reg == OP_READ) ? rdata_reg : 32'd0;

    // direct stores come from the walker, blended stores from the end of the pipe
    always_comb
    begin
        if (p2_valid_reg)
        begin
            we    = 1'b1;
            waddr = p2_addr_reg;
            wdata = {8'd0, div255(sum_r_reg), div255(sum_g_reg), div255(sum_b_reg)};
        end
        else
        begin
            we    = (state_reg == S_RUN) && (op_reg == OP_SET);
            waddr = addr;
            wdata = color_reg;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        kind_next     = kind_reg;
        x0_next       = x0_reg;
        x1_next       = x1_reg;
        x_next        = x_reg;
        rows_next     = rows_reg;
        w_next        = w_reg;
        base_next     = base_reg;
        color_next    = color_reg;
        p1_valid_next = (state_reg == S_RUN) && (op_reg == OP_BLEND);
        p2_valid_next = p1_valid_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    op_next    = q_job.op;
                    kind_next  = q_job.kind;
                    x0_next    = q_job.x0;
                    x1_next    = q_job.x1;
                    x_next     = q_job.x0;
                    rows_next  = q_job.rows;
                    w_next     = q_job.w;
                    base_next  = q_base;
                    color_next = q_job.color;
                    state_next = (q_job.op == OP_SKIP) ? S_DRAIN : S_RUN;
                end
            end
            S_RUN:
            begin
                if (x_last)
                begin
                    x_next    = x0_reg;
                    base_next = base_reg + AW'(w_reg);
                    rows_next = rows_reg - 1'b1;
                    if (rows_reg == COORD_W'(1))
                        state_next = S_DRAIN;
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (pipe_empty)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        kind_reg    <= kind_next;
        x0_reg      <= x0_next;
        x1_reg      <= x1_next;
        x_reg       <= x_next;
        rows_reg    <= rows_next;
        w_reg       <= w_next;
        base_reg    <= base_next;
        color_reg   <= color_next;
        p1_addr_reg <= addr;
        p2_addr_reg <= p1_addr_reg;
        sum_r_reg   <= mix(alpha, color_reg[23:16], rdata_reg[23:16]);
        sum_g_reg   <= mix(alpha, color_reg[15:8], rdata_reg[15:8]);
        sum_b_reg   <= mix(alpha, color_reg[7:0], rdata_reg[7:0]);
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (rd_en)
            rdata_reg <= mem[addr];
    end

endmodule

[rtl/alpha_blend_rect_fill.sv]
// a command passes through the front register and the queue before the engine takes it; a fill
// then stores one pixel per cycle, rows chaining with no gap, and reports done once the blend
// pipe is empty; the frame store has separate read and write ports, so blending keeps the pace
// a two-entry queue lets the next command be taken while a fill is running
// reset clears all control state and sets width and height to 256; frame store contents stay
// undefined until written; done is a one-cycle strobe and cannot be stalled
module alpha_blend_rect_fill #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  abrf_pkg::cmd_t             cmd,
    output logic                       done,
    output abrf_pkg::rsp_t             result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [abrf_pkg::CFG_W-1:0] cfg_data
);
    import abrf_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;

    logic             push;
    job_t             push_job;
    logic [AW-1:0]    push_base;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    job_t             q_job;
    logic [AW-1:0]    q_base;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                CFG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_W'(256);
            frame_height_reg <= CFG_W'(256);
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    abrf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .push         (push),
        .push_job     (push_job),
        .push_base    (push_base),
        .q_full       (q_full)
    );

    abrf_queue #(
        .AW (AW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .push_base (push_base),
        .full      (q_full),
        .not_empty (q_valid),
        .pop       (q_pop),
        .pop_job   (q_job),
        .pop_base  (q_base)
    );

    abrf_back #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_base  (q_base),
        .q_pop   (q_pop),
        .done    (done),
        .result  (result)
    );

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import abrf_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_DIM = 256;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 20;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic done;
    rsp_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    alpha_blend_rect_fill dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the frame store and size registers
    logic [31:0] frame_mem [0:MAX_DIM*MAX_DIM-1];
    logic [CFG_W-1:0] frame_w_cfg = 9'd256;
    logic [CFG_W-1:0] frame_h_cfg = 9'd256;

    cmd_t cmd_backlog[$];
    rsp_t awaited_done[$];
    logic cmd_taken = 1'b0;
    int idle_pct = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int reg_writes = 0;
    int kind_count [4] = '{0, 0, 0, 0};

    int phase_w [PHASE_COUNT] = '{1, 0, 511, 37, 256, 173};
    int phase_h [PHASE_COUNT] = '{1, 9, 511, 200, 256, 0};
    int phase_idle [PHASE_COUNT] = '{0, 83, 0, 13, 83, 0};

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int eff_dim(logic [CFG_W-1:0] v);
        return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic int clamp_coord(int v, int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // updates the shadow frame and returns the done report for one request
    function automatic rsp_t apply_cmd_to_frame(cmd_t c);
        rsp_t r;
        int ew;
        int eh;
        int sx;
        int sy;
        int x0;
        int x1;
        int y0;
        int y1;
        int a;
        int idx;
        logic [31:0] old;
        logic [31:0] mixed;
        ew = eff_dim(frame_w_cfg);
        eh = eff_dim(frame_h_cfg);
        sx = int'(c.start_x);
        sy = int'(c.start_y);
        r = '0;
        r.done_kind = c.kind;
        case (c.kind)
            KIND_FILL:
            begin
                x0 = clamp_coord(sx, ew);
                x1 = clamp_coord(int'(c.end_x), ew);
                y0 = clamp_coord(sy, eh);
                y1 = clamp_coord(int'(c.end_y), eh);
                a = int'(c.color[31:24]);
                if (a != 0)
                begin
                    for (int y = y0; y < y1; y++)
                    begin
                        for (int x = x0; x < x1; x++)
                        begin
                            idx = y * ew + x;
                            if (a == 255)
                                frame_mem[idx] = c.color;
                            else
                            begin
                                old = frame_mem[idx];
                                mixed = '0;
                                for (int ch = 0; ch < 3; ch++)
                                    mixed[ch*8 +: 8] = 8'((a * c.color[ch*8 +: 8]
                                        + (255 - a) * old[ch*8 +: 8]) / 255);
                                frame_mem[idx] = mixed;
                            end
                        end
                    end
                end
            end
            KIND_WRITE:
            begin
                if (sx >= 0 && sy >= 0 && sx < ew && sy < eh)
                    frame_mem[sy * ew + sx] = c.color;
            end
            KIND_READ:
            begin
                if (sx >= 0 && sy >= 0 && sx < ew && sy < eh)
                    r.pixel_data = frame_mem[sy * ew + sx];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] pick_coord(int span);
        int roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return 16'($urandom);
        if (roll < 10)
            return roll[0] ? 16'h7fff : 16'h8000;
        return 16'($urandom_range(span + 2) - 2);
    endfunction

    function automatic cmd_t random_request();
        cmd_t c;
        int ew;
        int eh;
        int roll;
        logic [31:0] rgb;
        logic [7:0] alpha;
        ew = eff_dim(frame_w_cfg);
        eh = eff_dim(frame_h_cfg);
        rgb = $urandom;
        case ($urandom_range(7))
            0, 1: alpha = 8'hff;
            2: alpha = 8'h00;
            3: alpha = 8'h01;
            4: alpha = 8'hfe;
            default: alpha = 8'($urandom);
        endcase
        c.color = {alpha, rgb[23:0]};
        c.start_x = pick_coord(ew);
        c.start_y = pick_coord(eh);
        c.end_x = 16'($urandom);
        c.end_y = 16'($urandom);
        roll = $urandom_range(99);
        if (roll < 40)
        begin
            c.kind = KIND_FILL;
            // mostly small rectangles, a rare one may cover the whole frame
            if ($urandom_range(29) != 0)
            begin
                c.end_x = c.start_x + 16'($urandom_range(12));
                c.end_y = c.start_y + 16'($urandom_range(12));
            end
        end
        else if (roll < 65)
            c.kind = KIND_WRITE;
        else if (roll < 95)
            c.kind = KIND_READ;
        else
            c.kind = KIND_UNUSED;
        return c;
    endfunction

    task automatic queue_request(logic [1:0] kind, logic signed [15:0] sx,
                                 logic signed [15:0] sy, logic signed [15:0] ex,
                                 logic signed [15:0] ey, logic [31:0] color);
        cmd_t c;
        c.kind = kind;
        c.start_x = sx;
        c.start_y = sy;
        c.end_x = ex;
        c.end_y = ey;
        c.color = color;
        cmd_backlog.push_back(c);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_FRAME_WIDTH)
            frame_w_cfg = val;
        else
            frame_h_cfg = val;
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || awaited_done.size() != 0 || start || busy)
            @(negedge clk);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    endtask

    // request driver
    always @(negedge clk)
    begin : request_driver
        logic was_taken;
        was_taken = cmd_taken;
        if (was_taken)
        begin
            void'(cmd_backlog.pop_front());
            cmd_taken = 1'b0;
        end
        if (rst_n && (!start || was_taken))
        begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                start <= 1'b1;
                cmd <= cmd_backlog[0];
            end
            else
                start <= 1'b0;
        end
    end

    // acceptance and done checking
    always @(posedge clk)
    begin : done_monitor
        rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_done.size() == 0)
                    report_mismatch("done with nothing outstanding", result.pixel_data, '0);
                else
                begin
                    want = awaited_done.pop_front();
                    if (result.done_kind !== want.done_kind)
                        report_mismatch("done_kind", 32'(result.done_kind),
                                        32'(want.done_kind));
                    if (result.pixel_data !== want.pixel_data)
                        report_mismatch("pixel_data", result.pixel_data, want.pixel_data);
                end
            end
            if (start && !busy)
            begin
                awaited_done.push_back(apply_cmd_to_frame(cmd));
                kind_count[cmd.kind]++;
                cmd_taken = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // opaque fill over the whole store first, so every later read hits written pixels
        queue_request(KIND_FILL, -32768, -32768, 32767, 32767, 32'hff123456);
        queue_request(KIND_READ, 0, 0, 0, 0, 32'h0);
        queue_request(KIND_READ, 255, 255, 0, 0, 32'h0);
        queue_request(KIND_READ, 256, 0, 0, 0, 32'h0);
        queue_request(KIND_READ, -1, 7, 0, 0, 32'h0);
        queue_request(KIND_READ, -32768, 32767, 0, 0, 32'h0);
        queue_request(KIND_WRITE, 0, 0, 0, 0, 32'hffffffff);
        queue_request(KIND_WRITE, 255, 255, 0, 0, 32'h00000000);
        queue_request(KIND_WRITE, 256, 5, 0, 0, 32'hdeadbeef);
        queue_request(KIND_WRITE, 3, -1, 0, 0, 32'hcafef00d);
        queue_request(KIND_READ, 0, 0, 0, 0, 32'h0);
        queue_request(KIND_READ, 255, 255, 0, 0, 32'h0);
        // transparent fill, then a half blend over the corner
        queue_request(KIND_FILL, 0, 0, 8, 8, 32'h00abcdef);
        queue_request(KIND_FILL, 0, 0, 4, 4, 32'h80ff8000);
        // end below start and end equal to start draw nothing
        queue_request(KIND_FILL, 10, 10, 5, 20, 32'hff00ff00);
        queue_request(KIND_FILL, 2, 2, 2, 9, 32'hff00ff00);
        queue_request(KIND_READ, 1, 1, 0, 0, 32'h0);
        queue_request(KIND_READ, 0, 0, 0, 0, 32'h0);
        queue_request(KIND_FILL, 250, 250, 300, 300, 32'h01ffffff);
        queue_request(KIND_FILL, 254, 254, 256, 256, 32'hfe000000);
        queue_request(KIND_READ, 255, 255, 0, 0, 32'h0);
        queue_request(KIND_READ, 250, 251, 0, 0, 32'h0);
        queue_request(KIND_UNUSED, 5, 5, 6, 6, 32'hffffffff);
        queue_request(KIND_READ, 3, 0, 0, 0, 32'h0);
        wait_idle();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_reg(CFG_FRAME_WIDTH, CFG_W'(phase_w[p]));
            write_reg(CFG_FRAME_HEIGHT, CFG_W'(phase_h[p]));
            idle_pct = phase_idle[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
                cmd_backlog.push_back(random_request());
            wait_idle();
        end

        repeat (20) @(posedge clk);
        $display("covered %0d fills, %0d pixel writes, %0d pixel reads, %0d unused-kind requests",
                 kind_count[KIND_FILL], kind_count[KIND_WRITE], kind_count[KIND_READ],
                 kind_count[KIND_UNUSED]);
        $display("across %0d frame sizes with %0d register writes, %0d mismatches",
                 PHASE_COUNT + 1, reg_writes, mismatch_count);
        if (mismatch_count == 0 && awaited_done.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
